FILE: hdl/npem_pkg.sv
`timescale 1ns / 1ps

package npem_pkg;

    // Fixed field widths of the request, the result and the palette size
    localparam int ENTRY_W    = 8;
    localparam int COUNT_W    = 9;
    localparam int DIST_OUT_W = 26;

    // Reset value of the palette size register
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    // Request function codes
    typedef enum logic [0:0] {
        FUNC_LOAD = 1'b0,
        FUNC_MAP  = 1'b1
    } func_t;

endpackage

FILE: hdl/npem_cell.sv
`timescale 1ns / 1ps

module npem_cell
    import npem_pkg::*;
#(
    parameter int INDEX  = 0,
    parameter int COLOR_W = 4,
    parameter int FRAC_W  = 8,
    parameter int IDX_W   = 8
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic                             load_en,
    input  logic [COLOR_W+FRAC_W-1:0]        load_red,
    input  logic [COLOR_W+FRAC_W-1:0]        load_green,
    input  logic [COLOR_W+FRAC_W-1:0]        load_blue,
    input  logic [COUNT_W-1:0]               color_count,
    input  logic                             prev_valid,
    input  logic [3*COLOR_W-1:0]             prev_color,
    input  logic [IDX_W-1:0]                 prev_index,
    input  logic [2*(COLOR_W+FRAC_W)+1:0]    prev_dist,
    output logic                             next_valid,
    output logic [3*COLOR_W-1:0]             next_color,
    output logic [IDX_W-1:0]                 next_index,
    output logic [2*(COLOR_W+FRAC_W)+1:0]    next_dist
);

    localparam int MEAN_W = COLOR_W + FRAC_W;
    localparam int SQ_W   = 2 * MEAN_W;
    localparam int DIST_W = SQ_W + 2;
    localparam bit FIRST  = (INDEX == 0);
    localparam logic [COUNT_W-1:0] CELL_NUM = COUNT_W'(INDEX);
    localparam logic [IDX_W-1:0]   CELL_IDX = IDX_W'(INDEX);

    // Centroid held by this cell
    logic [MEAN_W-1:0] mean_red_reg, mean_green_reg, mean_blue_reg;

    // Stage A: squared component differences
    logic                 valid_a_reg;
    logic [3*COLOR_W-1:0] color_a_reg;
    logic [IDX_W-1:0]     index_a_reg;
    logic [DIST_W-1:0]    dist_a_reg;
    logic [SQ_W-1:0]      sq_red_a_reg, sq_green_a_reg, sq_blue_a_reg;
    logic [SQ_W-1:0]      sq_red_next, sq_green_next, sq_blue_next;

    // Stage B: running best
    logic                 valid_b_reg;
    logic [3*COLOR_W-1:0] color_b_reg;
    logic [IDX_W-1:0]     index_b_reg;
    logic [DIST_W-1:0]    dist_b_reg;
    logic [DIST_W-1:0]    sum_next;
    logic                 take_next;

    // Absolute difference of the scaled colour and a mean, squared
    function automatic logic [SQ_W-1:0] sq_diff(
        input logic [COLOR_W-1:0] color,
        input logic [MEAN_W-1:0]  mean
    );
        logic [MEAN_W-1:0] scaled;
        logic [MEAN_W-1:0] diff;
        scaled = {color, {FRAC_W{1'b0}}};
        diff   = (scaled >= mean) ? (scaled - mean) : (mean - scaled);
        return SQ_W'(diff) * SQ_W'(diff);
    endfunction

    // Centroid write
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            mean_red_reg   <= load_red;
            mean_green_reg <= load_green;
            mean_blue_reg  <= load_blue;
        end
    end

    // Squares of this cell
    always_comb
    begin
        sq_red_next   = sq_diff(prev_color[3*COLOR_W-1:2*COLOR_W], mean_red_reg);
        sq_green_next = sq_diff(prev_color[2*COLOR_W-1:COLOR_W], mean_green_reg);
        sq_blue_next  = sq_diff(prev_color[COLOR_W-1:0], mean_blue_reg);
    end

    // Sum and compare; entry 0 always opens the search, later ones take over only in range and strictly closer
    always_comb
    begin
        sum_next  = DIST_W'(sq_red_a_reg) + DIST_W'(sq_green_a_reg)
                  + DIST_W'(sq_blue_a_reg);
        take_next = FIRST || ((CELL_NUM < color_count) && (sum_next < dist_a_reg));
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_a_reg <= prev_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    // Payload of both stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            color_a_reg    <= prev_color;
            index_a_reg    <= prev_index;
            dist_a_reg     <= prev_dist;
            sq_red_a_reg   <= sq_red_next;
            sq_green_a_reg <= sq_green_next;
            sq_blue_a_reg  <= sq_blue_next;
            color_b_reg    <= color_a_reg;
            index_b_reg    <= take_next ? CELL_IDX : index_a_reg;
            dist_b_reg     <= take_next ? sum_next : dist_a_reg;
        end
    end

    assign next_valid = valid_b_reg;
    assign next_color = color_b_reg;
    assign next_index = index_b_reg;
    assign next_dist  = dist_b_reg;

endmodule

FILE: hdl/nearest_palette_entry_mapper.sv
`timescale 1ns / 1ps

// Channel   | Handshake            | Carries
// ----------+----------------------+------------------------------------------
// request   | in_valid / in_ready  | func, entry_index, mean_*, color_*
// result    | out_valid / out_ready| best_index, best_distance (map only)
// config    | cfg_write_en         | cfg_write_data -> color_count
//
// A map request enters the cell chain every cycle unless a stalled result
// holds the chain; its result passes two register stages per cell, the first
// loaded at the accepting edge, then the output register. A load writes its
// cell but is held off until no map is in flight, so loads between maps
// drain the chain.
// Reset clears only control state; centroids are undefined until loaded.
// A stalled result freezes the whole chain.

module nearest_palette_entry_mapper
    import npem_pkg::*;
#(
    parameter int MAX_COLORS     = 256,
    parameter int COMPONENT_BITS = 4,
    parameter int FRACTION_BITS  = 8
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write_en,
    input  logic [COUNT_W-1:0]                      cfg_write_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    func,
    input  logic [ENTRY_W-1:0]                      entry_index,
    input  logic [COMPONENT_BITS+FRACTION_BITS-1:0] mean_red,
    input  logic [COMPONENT_BITS+FRACTION_BITS-1:0] mean_green,
    input  logic [COMPONENT_BITS+FRACTION_BITS-1:0] mean_blue,
    input  logic [COMPONENT_BITS-1:0]               color_red,
    input  logic [COMPONENT_BITS-1:0]               color_green,
    input  logic [COMPONENT_BITS-1:0]               color_blue,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [ENTRY_W-1:0]                      best_index,
    output logic [DIST_OUT_W-1:0]                   best_distance
);

    localparam int MEAN_W = COMPONENT_BITS + FRACTION_BITS;
    localparam int DIST_W = 2 * MEAN_W + 2;
    localparam int IDX_W  = $clog2(MAX_COLORS);
    localparam int CNT_W  = $clog2(2 * MAX_COLORS + 2);

    logic [COUNT_W-1:0] color_count_reg;
    logic [CNT_W-1:0]   inflight_reg, inflight_next;
    logic               advance;
    logic               in_fire, map_fire, load_fire, out_fire;

    logic                      chain_valid [0:MAX_COLORS];
    logic [3*COMPONENT_BITS-1:0] chain_color [0:MAX_COLORS];
    logic [IDX_W-1:0]          chain_index [0:MAX_COLORS];
    logic [DIST_W-1:0]         chain_dist  [0:MAX_COLORS];

    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic [DIST_W-1:0] out_dist_reg;

    // Chain moves unless a result is waiting and not taken
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance && ((func == FUNC_MAP) || (inflight_reg == '0));
    assign in_fire   = in_valid && in_ready;
    assign map_fire  = in_fire && (func == FUNC_MAP);
    assign load_fire = in_fire && (func == FUNC_LOAD);
    assign out_fire  = out_valid_reg && out_ready;

    // Palette size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            color_count_reg <= COUNT_RESET;
        else if (cfg_write_en)
            color_count_reg <= cfg_write_data;
    end

    // Maps in flight, output register included
    always_comb
    begin
        inflight_next = inflight_reg;
        if (map_fire && !out_fire)
            inflight_next = inflight_reg + CNT_W'(1);
        else if (!map_fire && out_fire)
            inflight_next = inflight_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    // Head of the chain
    assign chain_valid[0] = map_fire;
    assign chain_color[0] = {color_red, color_green, color_blue};
    assign chain_index[0] = '0;
    assign chain_dist[0]  = '0;

    // One cell per palette entry
    for (genvar i = 0; i < MAX_COLORS; i++)
    begin : g_cell
        npem_cell #(
            .INDEX   (i),
            .COLOR_W (COMPONENT_BITS),
            .FRAC_W  (FRACTION_BITS),
            .IDX_W   (IDX_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .advance     (advance),
            .load_en     (load_fire && (entry_index == ENTRY_W'(i))),
            .load_red    (mean_red),
            .load_green  (mean_green),
            .load_blue   (mean_blue),
            .color_count (color_count_reg),
            .prev_valid  (chain_valid[i]),
            .prev_color  (chain_color[i]),
            .prev_index  (chain_index[i]),
            .prev_dist   (chain_dist[i]),
            .next_valid  (chain_valid[i+1]),
            .next_color  (chain_color[i+1]),
            .next_index  (chain_index[i+1]),
            .next_dist   (chain_dist[i+1])
        );
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= chain_valid[MAX_COLORS];
    end

    always_ff @(posedge clk)
    begin
        if (advance && chain_valid[MAX_COLORS])
        begin
            out_index_reg <= chain_index[MAX_COLORS];
            out_dist_reg  <= chain_dist[MAX_COLORS];
        end
    end

    assign out_valid  = out_valid_reg;
    assign best_index = ENTRY_W'(out_index_reg);

    // Distance keeps its low bits
    if (DIST_W >= DIST_OUT_W)
    begin : g_dist_trunc
        assign best_distance = out_dist_reg[DIST_OUT_W-1:0];
    end
    else
    begin : g_dist_ext
        assign best_distance = DIST_OUT_W'(out_dist_reg);
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import npem_pkg::*;

    localparam int PALETTE_DEPTH = 256;
    localparam int COLOR_W       = 4;
    localparam int FRAC_W        = 8;
    localparam int MEAN_W        = COLOR_W + FRAC_W;
    localparam int MEAN_MAX      = (1 << MEAN_W) - 1;
    localparam int COLOR_MAX     = (1 << COLOR_W) - 1;
    // chain depth plus a margin, waited out before any register write
    localparam int SETTLE_CYCLES = 2 * PALETTE_DEPTH + 16;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct packed {
        func_t              op;
        logic [ENTRY_W-1:0] entry;
        logic [MEAN_W-1:0]  mean_r;
        logic [MEAN_W-1:0]  mean_g;
        logic [MEAN_W-1:0]  mean_b;
        logic [COLOR_W-1:0] color_r;
        logic [COLOR_W-1:0] color_g;
        logic [COLOR_W-1:0] color_b;
    } request_t;

    typedef struct packed {
        logic [ENTRY_W-1:0]    index;
        logic [DIST_OUT_W-1:0] distance;
    } match_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write_en = 1'b0;
    logic [COUNT_W-1:0]    cfg_write_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  func = 1'b0;
    logic [ENTRY_W-1:0]    entry_index = '0;
    logic [MEAN_W-1:0]     mean_red = '0;
    logic [MEAN_W-1:0]     mean_green = '0;
    logic [MEAN_W-1:0]     mean_blue = '0;
    logic [COLOR_W-1:0]    color_red = '0;
    logic [COLOR_W-1:0]    color_green = '0;
    logic [COLOR_W-1:0]    color_blue = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [ENTRY_W-1:0]    best_index;
    logic [DIST_OUT_W-1:0] best_distance;

    // pending requests, expected matches, and the predictor's own state
    request_t              pending_requests[$];
    match_t                expected_matches[$];
    logic [MEAN_W-1:0]     palette_r[PALETTE_DEPTH];
    logic [MEAN_W-1:0]     palette_g[PALETTE_DEPTH];
    logic [MEAN_W-1:0]     palette_b[PALETTE_DEPTH];
    logic [COUNT_W-1:0]    palette_size = COUNT_RESET;

    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    queued_total = 0;
    int                    accepted_total = 0;
    int                    load_count = 0;
    int                    map_count = 0;
    int                    checked_count = 0;
    int                    mismatch_count = 0;
    int                    cycle_count = 0;
    logic                  req_taken = 1'b0;
    request_t              drive_req;

    nearest_palette_entry_mapper u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .entry_index    (entry_index),
        .mean_red       (mean_red),
        .mean_green     (mean_green),
        .mean_blue      (mean_blue),
        .color_red      (color_red),
        .color_green    (color_green),
        .color_blue     (color_blue),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .best_index     (best_index),
        .best_distance  (best_distance)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // squared difference of one component, colour raised to the 4.8 scale
    function automatic longint comp_sq(logic [COLOR_W-1:0] c, logic [MEAN_W-1:0] m);
        longint scaled;
        longint d;
        scaled = longint'(c) << FRAC_W;
        d = scaled - longint'(m);
        return d * d;
    endfunction

    // exhaustive nearest search, lowest index on a tie
    function automatic match_t nearest_entry(request_t rq);
        int     searched;
        longint d;
        longint best_d;
        int     best_i;
        match_t m;
        searched = (palette_size == 0) ? 1 :
                   (palette_size > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(palette_size);
        best_i = 0;
        best_d = 0;
        for (int i = 0; i < searched; i++)
        begin
            d = comp_sq(rq.color_r, palette_r[i]) + comp_sq(rq.color_g, palette_g[i])
              + comp_sq(rq.color_b, palette_b[i]);
            if (i == 0 || d < best_d)
            begin
                best_d = d;
                best_i = i;
            end
        end
        m.index = best_i[ENTRY_W-1:0];
        m.distance = best_d[DIST_OUT_W-1:0];
        return m;
    endfunction

    task automatic note_mismatch(string what, match_t want, match_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH %s: expected index %0d dist %0d, got index %0d dist %0d",
                     what, want.index, want.distance, got.index, got.distance);
    endtask

    // driver: new request at the falling edge once the last one was taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || req_taken))
        begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                drive_req = pending_requests.pop_front();
                in_valid    <= 1'b1;
                func        <= drive_req.op;
                entry_index <= drive_req.entry;
                mean_red    <= drive_req.mean_r;
                mean_green  <= drive_req.mean_g;
                mean_blue   <= drive_req.mean_b;
                color_red   <= drive_req.color_r;
                color_green <= drive_req.color_g;
                color_blue  <= drive_req.color_b;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: check results, then predict from the accepted request
    always @(posedge clk)
    begin : monitor
        match_t got;
        match_t want;
        request_t rq;
        got.index = best_index;
        got.distance = best_distance;
        if (out_valid && out_ready)
        begin
            if (expected_matches.size() == 0)
            begin
                want = '0;
                note_mismatch("unexpected result", want, got);
            end
            else
            begin
                want = expected_matches.pop_front();
                checked_count++;
                if (got.index !== want.index || got.distance !== want.distance)
                    note_mismatch("result", want, got);
            end
        end
        if (in_valid && in_ready)
        begin
            rq.op = func_t'(func);
            rq.entry = entry_index;
            rq.mean_r = mean_red;
            rq.mean_g = mean_green;
            rq.mean_b = mean_blue;
            rq.color_r = color_red;
            rq.color_g = color_green;
            rq.color_b = color_blue;
            accepted_total++;
            if (rq.op == FUNC_LOAD)
            begin
                palette_r[rq.entry] = rq.mean_r;
                palette_g[rq.entry] = rq.mean_g;
                palette_b[rq.entry] = rq.mean_b;
                load_count++;
            end
            else
            begin
                expected_matches.push_back(nearest_entry(rq));
                map_count++;
            end
        end
        req_taken <= in_valid && in_ready;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_load(int idx, int r, int g, int b);
        request_t rq;
        rq = '0;
        rq.op = FUNC_LOAD;
        rq.entry = idx[ENTRY_W-1:0];
        rq.mean_r = r[MEAN_W-1:0];
        rq.mean_g = g[MEAN_W-1:0];
        rq.mean_b = b[MEAN_W-1:0];
        pending_requests.push_back(rq);
        queued_total++;
    endtask

    task automatic queue_map(int r, int g, int b);
        request_t rq;
        rq = '0;
        rq.op = FUNC_MAP;
        rq.color_r = r[COLOR_W-1:0];
        rq.color_g = g[COLOR_W-1:0];
        rq.color_b = b[COLOR_W-1:0];
        pending_requests.push_back(rq);
        queued_total++;
    endtask

    // wait until every request is taken and every result is back, then let the chain settle
    task automatic drain();
        while (accepted_total != queued_total || expected_matches.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_palette_size(int value);
        drain();
        cfg_write_en <= 1'b1;
        cfg_write_data <= value[COUNT_W-1:0];
        palette_size = value[COUNT_W-1:0];
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    function automatic int rand_mean();
        int v;
        // a quarter land on the colour grid so exact hits and ties occur
        if ($urandom_range(3) == 0)
            v = $urandom_range(COLOR_MAX) << FRAC_W;
        else
            v = $urandom_range(MEAN_MAX);
        return v;
    endfunction

    function automatic int rand_color();
        int v;
        case ($urandom_range(7))
            0:       v = 0;
            1:       v = COLOR_MAX;
            default: v = $urandom_range(COLOR_MAX);
        endcase
        return v;
    endfunction

    initial
    begin : stimulus
        int sizes[8];
        int lim;
        int idx;
        int v;
        sizes = '{256, 511, 1, 0, 128, 255, 2, 0};
        sizes[7] = $urandom_range(3, 254);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // size zero searches entry 0 alone: farthest centroid gives the largest distance
        write_palette_size(0);
        queue_load(0, MEAN_MAX, MEAN_MAX, MEAN_MAX);
        queue_map(0, 0, 0);
        queue_map(COLOR_MAX, COLOR_MAX, COLOR_MAX);

        // four entries, equal centroids at 1 and 3, top entry loaded but outside the search
        write_palette_size(4);
        queue_load(0, 0, 0, 0);
        queue_load(1, MEAN_MAX, MEAN_MAX, MEAN_MAX);
        queue_load(2, 'hAAA, 'h555, COLOR_MAX << FRAC_W);
        queue_load(3, MEAN_MAX, MEAN_MAX, MEAN_MAX);
        queue_load(PALETTE_DEPTH - 1, 'h123, 'h456, 'h789);
        queue_map(0, 0, 0);
        queue_map(COLOR_MAX, COLOR_MAX, COLOR_MAX);
        queue_map(10, 5, COLOR_MAX);
        queue_map(8, 8, 8);
        queue_map(COLOR_MAX, 0, COLOR_MAX);
        queue_map(0, COLOR_MAX, 0);

        // fill the whole palette so any size is safe to search
        write_palette_size(256);
        for (int i = 0; i < PALETTE_DEPTH; i++)
            queue_load(i, rand_mean(), rand_mean(), rand_mean());

        // random phases over sizes and idle/stall mixes
        for (int ph = 0; ph < 8; ph++)
        begin
            write_palette_size(sizes[ph]);
            case (ph % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            lim = (sizes[ph] == 0) ? 1 : (sizes[ph] > PALETTE_DEPTH) ? PALETTE_DEPTH
                                                                      : sizes[ph];
            for (int blk = 0; blk < 2; blk++)
            begin
                v = $urandom_range(8);
                for (int k = 0; k < v; k++)
                begin
                    if ($urandom_range(3) != 0)
                        idx = $urandom_range(lim - 1);
                    else
                        idx = $urandom_range(PALETTE_DEPTH - 1);
                    queue_load(idx, rand_mean(), rand_mean(), rand_mean());
                end
                v = $urandom_range(15, 30);
                for (int k = 0; k < v; k++)
                    queue_map(rand_color(), rand_color(), rand_color());
            end
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        $display("Summary: %0d loads, %0d maps, %0d results checked, %0d mismatches",
                 load_count, map_count, checked_count, mismatch_count);
        $display("Palette sizes 0 to 511 covered under four sender idle / receiver stall mixes");
        if (mismatch_count == 0 && expected_matches.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: nearest_palette_entry_mapper.f
hdl/npem_pkg.sv
hdl/npem_cell.sv
hdl/nearest_palette_entry_mapper.sv
sim/testbench.sv
